/* sv/lpht_pkg.sv */
// Shared types and constants for the linear-probe hash table.
`default_nettype none
package lpht_pkg;

	localparam int unsigned DEPTH_DEF      = 1024;
	localparam int unsigned KEY_BITS_DEF   = 32;
	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam logic [63:0] GOLDEN_MULT    = 64'd11400714819323198485;
	localparam logic [10:0] FILL_RESET     = 11'd512;
	localparam logic [1:0]  ADDR_FILL_LIMIT = 2'd0;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_REMOVED  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// Datapath commands
	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_LOAD,      // latch request, start home hash
		CMD_HASH,      // wait on the home hash, load probe pointer when done
		CMD_READ,      // issue memory read at probe pointer, remember slot
		CMD_SREAD,     // memory read during the shift, hit slot kept
		CMD_NEXT,      // advance probe pointer
		CMD_WR_NEW,    // write new entry at probe pointer
		CMD_WR_VAL,    // write value at probe pointer
		CMD_HOLE,      // open hole at probe slot, point at next
		CMD_HREAD,     // start home hash of read entry
		CMD_MOVE,      // move read entry into hole, hole <= pointer, point at next
		CMD_CLR_HOLE,  // clear valid at the final hole
		CMD_RESULT     // register result
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		status_t     status;
		logic        use_slot;
		logic        use_val;
		logic [1:0]  cnt_op;   // 0 keep, 1 inc, 2 dec
	} ctrl_t;

	typedef struct packed {
		op_t  op;
		logic hash_done;
		logic rd_valid;
		logic rd_match;
		logic probe_end;   // visited every slot
		logic below_limit;
		logic mover;       // read entry may move back into the hole
		logic clearing;    // valid memory clearing pass after reset
	} stat_t;

	localparam logic [1:0] CNT_KEEP = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;

endpackage
`default_nettype wire

/* sv/lpht_home.sv */
// Multi-cycle Fibonacci home-slot unit, 16x64 partial products.
`default_nettype none
module lpht_home #(
	parameter int unsigned DEPTH = lpht_pkg::DEPTH_DEF,
	localparam int unsigned IW = $clog2(DEPTH),
	localparam int unsigned L  = $clog2(DEPTH + 1) - 1
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire [63:0]     hash,
	output logic           done,
	output logic [IW-1:0]  home
);
	// L is floor(log2(DEPTH))
	logic [63:0] hx_q;
	logic [63:0] acc_q;
	logic [2:0]  step_q;
	logic        busy_q;
	logic [63:0] part;
	logic [63:0] top;

	assign part = (hx_q * {48'd0, lpht_pkg::GOLDEN_MULT[16*step_q[1:0] +: 16]})
		<< (16 * step_q[1:0]);
	assign top = acc_q >> (64 - L);
	// top < 2**L <= DEPTH, so it is already a slot index
	assign home = IW'(top);
	assign done = !busy_q && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd3)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hx_q  <= hash ^ (hash >> (64 - L));
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part;
		end
	end
endmodule
`default_nettype wire

/* sv/lpht_datapath.sv */
// Datapath: request registers, slot memories, probe and hole pointers.
`default_nettype none
module lpht_datapath #(
	parameter int unsigned DEPTH      = lpht_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
	localparam int unsigned IW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lpht_pkg::ctrl_t       ctrl,
	output lpht_pkg::stat_t       stat,
	input  wire [1:0]             in_op,
	input  wire [63:0]            in_hash,
	input  wire [31:0]            in_key,
	input  wire [31:0]            in_value,
	input  wire [10:0]            fill_limit,
	output logic [2:0]            res_status,
	output logic [31:0]           res_value,
	output logic [9:0]            res_slot,
	output logic [10:0]           res_count
);
	logic                   valid_mem [DEPTH];
	logic [63:0]            hash_mem [DEPTH];
	logic [KEY_BITS-1:0]    key_mem  [DEPTH];
	logic [VALUE_BITS-1:0]  val_mem  [DEPTH];

	logic [1:0]             op_q;
	logic [63:0]            hash_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [IW-1:0]          ptr_q, hole_q, hit_q;
	logic [CW-1:0]          visited_q;
	logic [CW-1:0]          count_q;
	logic                   clr_busy_q;
	logic [IW-1:0]          clr_idx_q;

	logic                   rv_q;
	logic [63:0]            rh_q;
	logic [KEY_BITS-1:0]    rk_q;
	logic [VALUE_BITS-1:0]  rval_q;

	logic                   hstart;
	logic [63:0]            hsrc;
	logic                   hdone;
	logic [IW-1:0]          hhome;
	logic [IW-1:0]          ptr_next;
	logic [IW:0]            d_home, d_hole;

	assign hstart = ctrl.cmd == lpht_pkg::CMD_LOAD || ctrl.cmd == lpht_pkg::CMD_HREAD;
	assign hsrc = (ctrl.cmd == lpht_pkg::CMD_LOAD)
		? ((in_hash == '1) ? in_hash - 64'd1 : in_hash) : rh_q;

	lpht_home #(.DEPTH(DEPTH)) u_home (
		.clk(clk), .arst_n(arst_n), .start(hstart), .hash(hsrc),
		.done(hdone), .home(hhome)
	);

	assign ptr_next = (ptr_q == IW'(DEPTH - 1)) ? '0 : ptr_q + IW'(1);

	// cyclic distances home->ptr and hole->ptr
	assign d_home = (ptr_q >= hhome) ? {1'b0, ptr_q - hhome}
		: (IW+1)'(ptr_q) + (IW+1)'(DEPTH) - (IW+1)'(hhome);
	assign d_hole = (ptr_q >= hole_q) ? {1'b0, ptr_q - hole_q}
		: (IW+1)'(ptr_q) + (IW+1)'(DEPTH) - (IW+1)'(hole_q);

	assign stat.op          = lpht_pkg::op_t'(op_q);
	assign stat.hash_done   = hdone;
	assign stat.rd_valid    = rv_q;
	assign stat.rd_match    = rh_q == hash_q && rk_q == key_q;
	assign stat.probe_end   = visited_q == CW'(DEPTH);
	assign stat.below_limit = 11'(count_q) < fill_limit;
	assign stat.mover       = d_home >= d_hole;
	assign stat.clearing    = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			count_q    <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + IW'(1);
				if (clr_idx_q == IW'(DEPTH - 1))
					clr_busy_q <= 1'b0;
			end
			if (ctrl.cmd == lpht_pkg::CMD_RESULT) begin
				case (ctrl.cnt_op)
					lpht_pkg::CNT_INC: count_q <= count_q + CW'(1);
					lpht_pkg::CNT_DEC: if (count_q != '0) count_q <= count_q - CW'(1);
					default: ;
				endcase
			end
		end
	end

	// one valid write per cycle; the vacated slot of a shift is cleared once at the end
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			valid_mem[clr_idx_q] <= 1'b0;
		else if (ctrl.cmd == lpht_pkg::CMD_WR_NEW)
			valid_mem[ptr_q] <= 1'b1;
		else if (ctrl.cmd == lpht_pkg::CMD_CLR_HOLE)
			valid_mem[hole_q] <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			lpht_pkg::CMD_LOAD: begin
				op_q      <= in_op;
				hash_q    <= hsrc;
				key_q     <= KEY_BITS'(in_key);
				val_q     <= VALUE_BITS'(in_value);
				visited_q <= '0;
			end
			lpht_pkg::CMD_HASH: if (hdone) ptr_q <= hhome;
			lpht_pkg::CMD_READ, lpht_pkg::CMD_SREAD: begin
				rv_q   <= valid_mem[ptr_q];
				rh_q   <= hash_mem[ptr_q];
				rk_q   <= key_mem[ptr_q];
				rval_q <= val_mem[ptr_q];
				if (ctrl.cmd == lpht_pkg::CMD_READ)
					hit_q <= ptr_q;
			end
			lpht_pkg::CMD_NEXT: begin
				ptr_q     <= ptr_next;
				visited_q <= visited_q + CW'(1);
			end
			lpht_pkg::CMD_WR_NEW: begin
				hash_mem[ptr_q] <= hash_q;
				key_mem[ptr_q]  <= key_q;
				val_mem[ptr_q]  <= val_q;
			end
			lpht_pkg::CMD_WR_VAL: val_mem[ptr_q] <= val_q;
			lpht_pkg::CMD_HOLE: begin
				hole_q    <= ptr_q;
				ptr_q     <= ptr_next;
				visited_q <= CW'(1);
			end
			lpht_pkg::CMD_MOVE: begin
				hash_mem[hole_q] <= rh_q;
				key_mem[hole_q]  <= rk_q;
				val_mem[hole_q]  <= rval_q;
				hole_q           <= ptr_q;
				ptr_q            <= ptr_next;
				visited_q        <= visited_q + CW'(1);
			end
			lpht_pkg::CMD_RESULT: begin
				res_status <= ctrl.status;
				res_value  <= ctrl.use_val ? 32'(rval_q) : '0;
				res_slot   <= ctrl.use_slot ? 10'(hit_q) : '0;
				case (ctrl.cnt_op)
					lpht_pkg::CNT_INC: res_count <= 11'(count_q + CW'(1));
					lpht_pkg::CNT_DEC:
						res_count <= (count_q != '0) ? 11'(count_q - CW'(1)) : '0;
					default: res_count <= 11'(count_q);
				endcase
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* sv/lpht_ctrl.sv */
// Controller: sequences probe, insert, update and backward-shift removal.
`default_nettype none
module lpht_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_fire,
	input  wire             out_free,
	input  lpht_pkg::stat_t stat,
	output lpht_pkg::ctrl_t ctrl,
	output logic            busy,
	output logic            res_valid_set
);
	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_READ, S_CHECK, S_SH_READ, S_SH_CHECK, S_SH_HASH, S_DONE
	} state_t;

	state_t           state_q;
	lpht_pkg::ctrl_t  res_q;

	assign busy = state_q != S_IDLE || stat.clearing;
	assign res_valid_set = state_q == S_DONE && out_free;

	always_comb begin
		ctrl = res_q;
		ctrl.cmd = lpht_pkg::CMD_IDLE;
		case (state_q)
			S_IDLE:    if (in_fire) ctrl.cmd = lpht_pkg::CMD_LOAD;
			S_HASH:    ctrl.cmd = lpht_pkg::CMD_HASH;
			S_READ:    ctrl.cmd = lpht_pkg::CMD_READ;
			S_CHECK: begin
				if (stat.probe_end) ctrl.cmd = lpht_pkg::CMD_IDLE;
				else if (!stat.rd_valid) begin
					if (stat.op == lpht_pkg::OP_INSERT && stat.below_limit)
						ctrl.cmd = lpht_pkg::CMD_WR_NEW;
				end else if (stat.rd_match) begin
					if (stat.op == lpht_pkg::OP_INSERT) ctrl.cmd = lpht_pkg::CMD_WR_VAL;
					else if (stat.op == lpht_pkg::OP_REMOVE) ctrl.cmd = lpht_pkg::CMD_HOLE;
				end else ctrl.cmd = lpht_pkg::CMD_NEXT;
			end
			S_SH_READ:  ctrl.cmd = lpht_pkg::CMD_SREAD;
			S_SH_CHECK: ctrl.cmd = (stat.rd_valid && !stat.probe_end) ? lpht_pkg::CMD_HREAD
				: lpht_pkg::CMD_CLR_HOLE;
			S_SH_HASH: if (stat.hash_done)
				ctrl.cmd = stat.mover ? lpht_pkg::CMD_MOVE : lpht_pkg::CMD_NEXT;
			S_DONE:    if (out_free) ctrl.cmd = lpht_pkg::CMD_RESULT;
			default:   ctrl.cmd = lpht_pkg::CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_HASH;
				S_HASH: if (stat.hash_done) begin
					if (stat.op == lpht_pkg::OP_NONE) begin
						res_q <= '{lpht_pkg::CMD_IDLE, lpht_pkg::ST_NOTFOUND, 1'b0, 1'b0,
							lpht_pkg::CNT_KEEP};
						state_q <= S_DONE;
					end else state_q <= S_READ;
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= S_DONE;
					if (stat.probe_end) begin
						res_q <= '{lpht_pkg::CMD_IDLE,
							(stat.op == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
							: lpht_pkg::ST_NOTFOUND, 1'b0, 1'b0, lpht_pkg::CNT_KEEP};
					end else if (!stat.rd_valid) begin
						if (stat.op != lpht_pkg::OP_INSERT)
							res_q <= '{lpht_pkg::CMD_IDLE, lpht_pkg::ST_NOTFOUND, 1'b0, 1'b0,
								lpht_pkg::CNT_KEEP};
						else if (stat.below_limit)
							res_q <= '{lpht_pkg::CMD_IDLE, lpht_pkg::ST_INSERTED, 1'b1, 1'b0,
								lpht_pkg::CNT_INC};
						else
							res_q <= '{lpht_pkg::CMD_IDLE, lpht_pkg::ST_FULL, 1'b0, 1'b0,
								lpht_pkg::CNT_KEEP};
					end else if (stat.rd_match) begin
						case (stat.op)
							lpht_pkg::OP_INSERT: res_q <= '{lpht_pkg::CMD_IDLE,
								lpht_pkg::ST_UPDATED, 1'b1, 1'b0, lpht_pkg::CNT_KEEP};
							lpht_pkg::OP_LOOKUP: res_q <= '{lpht_pkg::CMD_IDLE,
								lpht_pkg::ST_FOUND, 1'b1, 1'b1, lpht_pkg::CNT_KEEP};
							default: begin
								res_q <= '{lpht_pkg::CMD_IDLE, lpht_pkg::ST_REMOVED, 1'b1,
									1'b0, lpht_pkg::CNT_DEC};
								state_q <= S_SH_READ;
							end
						endcase
					end else state_q <= S_READ;
				end
				S_SH_READ: state_q <= S_SH_CHECK;
				// hit_q keeps the hit slot; result slot taken from the hit read
				S_SH_CHECK: state_q <= (stat.rd_valid && !stat.probe_end) ? S_SH_HASH : S_DONE;
				S_SH_HASH: if (stat.hash_done) state_q <= S_SH_READ;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/linear_probe_hash_table.sv */
// Top level: linear-probing hash table with Fibonacci home slot.
//
// channel  dir  handshake                 payload
// s_axis   in   s_tvalid / s_tready       s_tdata = op, key_hash, key, value
// m_axis   out  m_tvalid / m_tready       m_tdata = status, value_out, slot_index, entry_count
// apb      in   psel/penable/pwrite/pready fill_limit at address 0
//
// Each transaction runs the home hash (a 4-step 16x64 multiply); all but a no-op then
// read and check each probed slot in turn; a remove then shifts back those slots after the
// hit that may move, rehashing each one it examines. One request is in flight at a time.
// After reset a clearing pass over all TABLE_DEPTH slots empties the valid memory; s_tready
// stays low until it ends.
// A finished result sits in the output register; the next request is taken meanwhile
// only once the controller is free.
`default_nettype none
module linear_probe_hash_table #(
	parameter int unsigned TABLE_DEPTH = lpht_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS    = lpht_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [135:0] s_tdata,   // op[1:0], key_hash[65:2], key[97:66], value[129:98]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // status[2:0], value_out[34:3], slot_index[44:35],
	                               // entry_count[55:45]
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [1:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [10:0]      fill_q;
	lpht_pkg::ctrl_t  ctrl;
	lpht_pkg::stat_t  stat;
	logic             busy, res_set, in_fire, out_free;
	logic [2:0]       r_status;
	logic [31:0]      r_value;
	logic [9:0]       r_slot;
	logic [10:0]      r_count;

	assign pready   = 1'b1;
	assign prdata   = (paddr == lpht_pkg::ADDR_FILL_LIMIT) ? {21'd0, fill_q} : '0;
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign m_tdata  = {r_count, r_slot, r_value, r_status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= lpht_pkg::FILL_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == lpht_pkg::ADDR_FILL_LIMIT)
				fill_q <= pwdata[10:0];
			if (res_set) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	lpht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.stat(stat), .ctrl(ctrl), .busy(busy), .res_valid_set(res_set)
	);

	lpht_datapath #(.DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.in_op(s_tdata[1:0]), .in_hash(s_tdata[65:2]), .in_key(s_tdata[97:66]),
		.in_value(s_tdata[129:98]), .fill_limit(fill_q),
		.res_status(r_status), .res_value(r_value), .res_slot(r_slot), .res_count(r_count)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("input taken while busy");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_set |=> m_tvalid) else $error("result lost");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd5) else $error("bad status");
endmodule
`default_nettype wire

/* tb/linear_probe_hash_table_tb.sv */
// Self-checking testbench for linear_probe_hash_table: directed table, then random traffic.
`default_nettype none
module linear_probe_hash_table_tb;

	localparam int DEPTH = 1024;
	localparam int POOL = 48;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [63:0] ALL_ONES = '1;

	typedef struct {
		lpht_pkg::status_t st;
		logic [31:0] val;
		logic [9:0]  slot;
		logic [10:0] cnt;
	} result_t;

	typedef struct {
		lpht_pkg::op_t op;
		int          pool_idx;   // -1: use hash/key below
		logic [63:0] hash;
		logic [31:0] key;
		logic [31:0] val;
		bit          typed;
		result_t     exp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [135:0] s_tdata = '0;   // op[1:0], key_hash[65:2], key[97:66], value[129:98]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // status[2:0], value_out[34:3], slot_index[44:35],
	                              // entry_count[55:45]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	linear_probe_hash_table dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table shadow
	bit          tbl_valid [DEPTH];
	logic [63:0] tbl_hash [DEPTH];
	logic [31:0] tbl_key [DEPTH];
	logic [31:0] tbl_val [DEPTH];
	int          tbl_count;
	logic [10:0] fill_limit;

	result_t     pending_results [$];
	logic [63:0] pool_hash [POOL];
	logic [31:0] pool_key [POOL];
	int          errors = 0;
	int          cycles = 0;
	int          tx_idle = 0;
	int          rx_idle = 0;
	row_t        rows [24];

	function automatic logic [9:0] home_of(logic [63:0] h);
		logic [63:0] x;
		x = h ^ (h >> 54);
		x = lpht_pkg::GOLDEN_MULT * x;
		return x[63:54];
	endfunction

	function automatic int ring_dist(int from, int to);
		return (to >= from) ? to - from : to + DEPTH - from;
	endfunction

	function automatic void backshift_remove(int hole);
		int j;
		j = (hole + 1) % DEPTH;
		tbl_valid[hole] = 0;
		for (int n = 1; n < DEPTH && tbl_valid[j]; n++) begin
			if (ring_dist(int'(home_of(tbl_hash[j])), j) >= ring_dist(hole, j)) begin
				tbl_valid[hole] = 1;
				tbl_hash[hole] = tbl_hash[j];
				tbl_key[hole] = tbl_key[j];
				tbl_val[hole] = tbl_val[j];
				tbl_valid[j] = 0;
				hole = j;
			end
			j = (j + 1) % DEPTH;
		end
		if (tbl_count > 0) tbl_count--;
	endfunction

	function automatic result_t hash_table_apply(lpht_pkg::op_t op, logic [63:0] h,
			logic [31:0] k, logic [31:0] v);
		result_t r;
		int i, at, fr;
		bit hit, has_free;
		r = '{lpht_pkg::ST_NOTFOUND, '0, '0, '0};
		if (h == ALL_ONES) h = h - 64'd1;
		hit = 0; has_free = 0; at = 0; fr = 0;
		if (op != lpht_pkg::OP_NONE) begin
			i = int'(home_of(h));
			for (int n = 0; n < DEPTH; n++) begin
				if (!tbl_valid[i]) begin
					has_free = 1; fr = i; break;
				end
				if (tbl_hash[i] == h && tbl_key[i] == k) begin
					hit = 1; at = i; break;
				end
				i = (i + 1) % DEPTH;
			end
			case (op)
				lpht_pkg::OP_INSERT: begin
					if (hit) begin
						tbl_val[at] = v; r.st = lpht_pkg::ST_UPDATED; r.slot = 10'(at);
					end else if (!has_free || tbl_count >= fill_limit) begin
						r.st = lpht_pkg::ST_FULL;
					end else begin
						tbl_valid[fr] = 1; tbl_hash[fr] = h; tbl_key[fr] = k; tbl_val[fr] = v;
						tbl_count++;
						r.st = lpht_pkg::ST_INSERTED; r.slot = 10'(fr);
					end
				end
				lpht_pkg::OP_LOOKUP: if (hit) begin
					r.st = lpht_pkg::ST_FOUND; r.val = tbl_val[at]; r.slot = 10'(at);
				end
				default: if (hit) begin
					backshift_remove(at); r.st = lpht_pkg::ST_REMOVED; r.slot = 10'(at);
				end
			endcase
		end
		r.cnt = 11'(tbl_count);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// sender: one transaction, with a random gap before it per the current idle rate
	task automatic send_request(lpht_pkg::op_t op, logic [63:0] h, logic [31:0] k,
			logic [31:0] v, bit typed = 0,
			result_t exp = '{lpht_pkg::ST_NOTFOUND, '0, '0, '0});
		result_t r;
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, v, k, h, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = hash_table_apply(op, h, k, v);
		pending_results.push_back(typed ? exp : r);
	endtask

	task automatic write_fill_limit(logic [10:0] lim);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= lpht_pkg::ADDR_FILL_LIMIT;
		pwdata <= {21'b0, lim};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		fill_limit = lim;
	endtask

	task automatic random_request();
		int p;
		int sel;
		logic [63:0] h;
		logic [31:0] k;
		lpht_pkg::op_t op;
		sel = $urandom_range(99);
		op = (sel < 45) ? lpht_pkg::OP_INSERT : (sel < 75) ? lpht_pkg::OP_LOOKUP
			: (sel < 97) ? lpht_pkg::OP_REMOVE : lpht_pkg::OP_NONE;
		p = $urandom_range(POOL - 1);
		h = pool_hash[p];
		k = pool_key[p];
		sel = $urandom_range(99);
		if (sel < 10) h = {$urandom, $urandom};
		else if (sel < 30) begin
			h = {$urandom, $urandom}; k = $urandom;
		end else if (sel < 33) h = ALL_ONES - 64'($urandom_range(1));
		send_request(op, h, k, $urandom);
	endtask

	// result side: check on accept, then pick the next tready
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], '0);
				end else begin
					e = pending_results.pop_front();
					if (m_tdata[2:0] != e.st)
						report_mismatch("status", 32'(m_tdata[2:0]), 32'(e.st));
					if (m_tdata[34:3] != e.val) report_mismatch("value_out", m_tdata[34:3], e.val);
					if (m_tdata[44:35] != e.slot)
						report_mismatch("slot_index", 32'(m_tdata[44:35]), 32'(e.slot));
					if (m_tdata[55:45] != e.cnt)
						report_mismatch("entry_count", 32'(m_tdata[55:45]), 32'(e.cnt));
				end
			end
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[linear_probe_hash_table] ERROR");
			$finish;
		end
	end

	initial begin
		result_t nf;
		logic [63:0] h;
		logic [63:0] hh;
		logic [31:0] kk;
		nf = '{lpht_pkg::ST_NOTFOUND, '0, '0, '0};
		foreach (tbl_valid[i]) tbl_valid[i] = 0;
		tbl_count = 0;
		fill_limit = lpht_pkg::FILL_RESET;
		// key pool clustered on a few home slots around the wrap point
		for (int i = 0; i < POOL; i++) begin
			do h = {$urandom, $urandom}; while (home_of(h) >= 4 && home_of(h) < 1020);
			pool_hash[i] = h;
			pool_key[i] = $urandom;
		end
		rows = '{
			'{lpht_pkg::OP_LOOKUP, -1, 64'd0, 32'd0, 32'd0, 1, nf},
			'{lpht_pkg::OP_REMOVE, -1, ALL_ONES, '1, '0, 1, nf},
			'{lpht_pkg::OP_NONE, -1, ALL_ONES, '1, '1, 1, nf},
			'{lpht_pkg::OP_INSERT, -1, ALL_ONES, '1, '1, 0, nf},
			'{lpht_pkg::OP_LOOKUP, -1, ALL_ONES - 64'd1, '1, '0, 0, nf},
			'{lpht_pkg::OP_INSERT, -1, 64'd0, 32'd0, 32'd0, 0, nf},
			'{lpht_pkg::OP_INSERT, -1, 64'd0, 32'd0, 32'h1234, 0, nf},
			'{lpht_pkg::OP_LOOKUP, -1, 64'd0, 32'd0, 32'd0, 0, nf},
			'{lpht_pkg::OP_INSERT, 0, '0, '0, 32'h10, 0, nf},
			'{lpht_pkg::OP_INSERT, 1, '0, '0, 32'h11, 0, nf},
			'{lpht_pkg::OP_INSERT, 2, '0, '0, 32'h12, 0, nf},
			'{lpht_pkg::OP_INSERT, 3, '0, '0, 32'h13, 0, nf},
			'{lpht_pkg::OP_INSERT, 4, '0, '0, 32'h14, 0, nf},
			'{lpht_pkg::OP_INSERT, 5, '0, '0, 32'h15, 0, nf},
			'{lpht_pkg::OP_REMOVE, 1, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_LOOKUP, 2, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_LOOKUP, 3, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_LOOKUP, 4, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_REMOVE, 0, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_LOOKUP, 5, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_LOOKUP, 1, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_NONE, 5, '0, '0, '0, 0, nf},
			'{lpht_pkg::OP_REMOVE, -1, 64'd0, 32'd0, '0, 0, nf},
			'{lpht_pkg::OP_LOOKUP, -1, ALL_ONES, '1, '0, 0, nf}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			hh = (rows[i].pool_idx < 0) ? rows[i].hash : pool_hash[rows[i].pool_idx];
			kk = (rows[i].pool_idx < 0) ? rows[i].key : pool_key[rows[i].pool_idx];
			send_request(rows[i].op, hh, kk, rows[i].val, rows[i].typed, rows[i].exp);
		end

		// zero limit: new keys refused, existing keys still update
		write_fill_limit(11'd0);
		send_request(lpht_pkg::OP_INSERT, pool_hash[7], pool_key[7], 32'h77);
		send_request(lpht_pkg::OP_INSERT, pool_hash[5], pool_key[5], 32'h55);

		write_fill_limit(11'h7FF);
		tx_idle = 10; rx_idle = 77;
		repeat (250) random_request();
		write_fill_limit(11'd3);
		tx_idle = 77; rx_idle = 10;
		repeat (200) random_request();
		write_fill_limit(11'd1);
		repeat (40) random_request();
		write_fill_limit(11'd1024);
		tx_idle = 0; rx_idle = 0;
		repeat (250) random_request();

		// fill every slot, then probe a completely full table
		while (tbl_count < DEPTH)
			send_request(lpht_pkg::OP_INSERT, {$urandom, $urandom}, $urandom, $urandom);
		send_request(lpht_pkg::OP_INSERT, {$urandom, $urandom}, $urandom, $urandom);
		send_request(lpht_pkg::OP_LOOKUP, {$urandom, $urandom}, $urandom, '0);
		send_request(lpht_pkg::OP_REMOVE, {$urandom, $urandom}, $urandom, '0);
		send_request(lpht_pkg::OP_INSERT, pool_hash[2], pool_key[2], 32'h22);
		send_request(lpht_pkg::OP_REMOVE, pool_hash[2], pool_key[2], '0);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[linear_probe_hash_table] OK");
		else
			$display("[linear_probe_hash_table] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
